// ----- src/normal_vector_quantizer_assert.svh -----
// assertion macros for the normal vector quantizer checker
`ifndef NORMAL_VECTOR_QUANTIZER_ASSERT_SVH
`define NORMAL_VECTOR_QUANTIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define NVQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("normal_vector_quantizer: port check failed");

// next-cycle implication, sampled on clk, off during reset
`define NVQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("normal_vector_quantizer: port check failed");

`endif

// ----- src/nvq_pkg.sv -----
// shared types and constants of the normal vector quantizer
`timescale 1ns / 1ps
`default_nettype none

package nvq_pkg;

    localparam int TABLE_ENTRIES = 162;
    localparam int IDX_W         = 8;
    localparam int NORMAL_W      = 16;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // one unit normal, signed q1.14 per component
    typedef struct packed {
        logic signed [NORMAL_W-1:0] x;
        logic signed [NORMAL_W-1:0] y;
        logic signed [NORMAL_W-1:0] z;
    } normal_t;

    // control that travels with each table entry through the datapath
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } nvq_tag_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] best_idx;
    } nvq_result_t;

endpackage

`default_nettype wire

// ----- src/nvq_table_rom.sv -----
// read-only table of the 162 unit normals with a registered read port
`timescale 1ns / 1ps
`default_nettype none

module nvq_table_rom
    import nvq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output normal_t               rd_data
);

    localparam logic signed [NORMAL_W-1:0] K0    = NORMAL_W'(0);
    localparam logic signed [NORMAL_W-1:0] V5257 = NORMAL_W'(8614);
    localparam logic signed [NORMAL_W-1:0] V8507 = NORMAL_W'(13937);
    localparam logic signed [NORMAL_W-1:0] V4429 = NORMAL_W'(7256);
    localparam logic signed [NORMAL_W-1:0] V2389 = NORMAL_W'(3913);
    localparam logic signed [NORMAL_W-1:0] V8642 = NORMAL_W'(14159);
    localparam logic signed [NORMAL_W-1:0] V2952 = NORMAL_W'(4837);
    localparam logic signed [NORMAL_W-1:0] V9554 = NORMAL_W'(15654);
    localparam logic signed [NORMAL_W-1:0] V3090 = NORMAL_W'(5063);
    localparam logic signed [NORMAL_W-1:0] V5000 = NORMAL_W'(8192);
    localparam logic signed [NORMAL_W-1:0] V8090 = NORMAL_W'(13255);
    localparam logic signed [NORMAL_W-1:0] V1625 = NORMAL_W'(2662);
    localparam logic signed [NORMAL_W-1:0] V2629 = NORMAL_W'(4307);
    localparam logic signed [NORMAL_W-1:0] V9511 = NORMAL_W'(15582);
    localparam logic signed [NORMAL_W-1:0] ONE   = NORMAL_W'(16384);
    localparam logic signed [NORMAL_W-1:0] V1476 = NORMAL_W'(2419);
    localparam logic signed [NORMAL_W-1:0] V7166 = NORMAL_W'(11740);
    localparam logic signed [NORMAL_W-1:0] V6817 = NORMAL_W'(11169);
    localparam logic signed [NORMAL_W-1:0] V5878 = NORMAL_W'(9630);
    localparam logic signed [NORMAL_W-1:0] V4253 = NORMAL_W'(6969);
    localparam logic signed [NORMAL_W-1:0] V6882 = NORMAL_W'(11275);

    localparam normal_t NORMAL_TABLE [TABLE_ENTRIES] = '{
        '{-V5257, K0, V8507}, '{-V4429, V2389, V8642}, '{-V2952, K0, V9554},
        '{-V3090, V5000, V8090}, '{-V1625, V2629, V9511}, '{K0, K0, ONE},
        '{K0, V8507, V5257}, '{-V1476, V7166, V6817}, '{V1476, V7166, V6817},
        '{K0, V5257, V8507}, '{V3090, V5000, V8090}, '{V5257, K0, V8507},
        '{V2952, K0, V9554}, '{V4429, V2389, V8642}, '{V1625, V2629, V9511},
        '{-V6817, V1476, V7166}, '{-V8090, V3090, V5000}, '{-V5878, V4253, V6882},
        '{-V8507, V5257, K0}, '{-V8642, V4429, V2389}, '{-V7166, V6817, V1476},
        '{-V6882, V5878, V4253}, '{-V5000, V8090, V3090}, '{-V2389, V8642, V4429},
        '{-V4253, V6882, V5878}, '{-V7166, V6817, -V1476}, '{-V5000, V8090, -V3090},
        '{-V5257, V8507, K0}, '{K0, V8507, -V5257}, '{-V2389, V8642, -V4429},
        '{K0, V9554, -V2952}, '{-V2629, V9511, -V1625}, '{K0, ONE, K0},
        '{K0, V9554, V2952}, '{-V2629, V9511, V1625}, '{V2389, V8642, V4429},
        '{V2629, V9511, V1625}, '{V5000, V8090, V3090}, '{V2389, V8642, -V4429},
        '{V2629, V9511, -V1625}, '{V5000, V8090, -V3090}, '{V8507, V5257, K0},
        '{V7166, V6817, V1476}, '{V7166, V6817, -V1476}, '{V5257, V8507, K0},
        '{V4253, V6882, V5878}, '{V8642, V4429, V2389}, '{V6882, V5878, V4253},
        '{V8090, V3090, V5000}, '{V6817, V1476, V7166}, '{V5878, V4253, V6882},
        '{V9554, V2952, K0}, '{ONE, K0, K0}, '{V9511, V1625, V2629},
        '{V8507, -V5257, K0}, '{V9554, -V2952, K0}, '{V8642, -V4429, V2389},
        '{V9511, -V1625, V2629}, '{V8090, -V3090, V5000}, '{V6817, -V1476, V7166},
        '{V8507, K0, V5257}, '{V8642, V4429, -V2389}, '{V8090, V3090, -V5000},
        '{V9511, V1625, -V2629}, '{V5257, K0, -V8507}, '{V6817, V1476, -V7166},
        '{V6817, -V1476, -V7166}, '{V8507, K0, -V5257}, '{V8090, -V3090, -V5000},
        '{V8642, -V4429, -V2389}, '{V9511, -V1625, -V2629}, '{V1476, V7166, -V6817},
        '{V3090, V5000, -V8090}, '{V4253, V6882, -V5878}, '{V4429, V2389, -V8642},
        '{V5878, V4253, -V6882}, '{V6882, V5878, -V4253}, '{-V1476, V7166, -V6817},
        '{-V3090, V5000, -V8090}, '{K0, V5257, -V8507}, '{-V5257, K0, -V8507},
        '{-V4429, V2389, -V8642}, '{-V2952, K0, -V9554}, '{-V1625, V2629, -V9511},
        '{K0, K0, -ONE}, '{V2952, K0, -V9554}, '{V1625, V2629, -V9511},
        '{-V4429, -V2389, -V8642}, '{-V3090, -V5000, -V8090}, '{-V1625, -V2629, -V9511},
        '{K0, -V8507, -V5257}, '{-V1476, -V7166, -V6817}, '{V1476, -V7166, -V6817},
        '{K0, -V5257, -V8507}, '{V3090, -V5000, -V8090}, '{V4429, -V2389, -V8642},
        '{V1625, -V2629, -V9511}, '{V2389, -V8642, -V4429}, '{V5000, -V8090, -V3090},
        '{V4253, -V6882, -V5878}, '{V7166, -V6817, -V1476}, '{V6882, -V5878, -V4253},
        '{V5878, -V4253, -V6882}, '{K0, -V9554, -V2952}, '{K0, -ONE, K0},
        '{V2629, -V9511, -V1625}, '{K0, -V8507, V5257}, '{K0, -V9554, V2952},
        '{V2389, -V8642, V4429}, '{V2629, -V9511, V1625}, '{V5000, -V8090, V3090},
        '{V7166, -V6817, V1476}, '{V5257, -V8507, K0}, '{-V2389, -V8642, -V4429},
        '{-V5000, -V8090, -V3090}, '{-V2629, -V9511, -V1625}, '{-V8507, -V5257, K0},
        '{-V7166, -V6817, -V1476}, '{-V7166, -V6817, V1476}, '{-V5257, -V8507, K0},
        '{-V5000, -V8090, V3090}, '{-V2389, -V8642, V4429}, '{-V2629, -V9511, V1625},
        '{-V8642, -V4429, V2389}, '{-V8090, -V3090, V5000}, '{-V6882, -V5878, V4253},
        '{-V6817, -V1476, V7166}, '{-V4429, -V2389, V8642}, '{-V5878, -V4253, V6882},
        '{-V3090, -V5000, V8090}, '{-V1476, -V7166, V6817}, '{-V4253, -V6882, V5878},
        '{-V1625, -V2629, V9511}, '{V4429, -V2389, V8642}, '{V1625, -V2629, V9511},
        '{V3090, -V5000, V8090}, '{V1476, -V7166, V6817}, '{K0, -V5257, V8507},
        '{V4253, -V6882, V5878}, '{V5878, -V4253, V6882}, '{V6882, -V5878, V4253},
        '{-V9554, V2952, K0}, '{-V9511, V1625, V2629}, '{-ONE, K0, K0},
        '{-V8507, K0, V5257}, '{-V9554, -V2952, K0}, '{-V9511, -V1625, V2629},
        '{-V8642, V4429, -V2389}, '{-V9511, V1625, -V2629}, '{-V8090, V3090, -V5000},
        '{-V8642, -V4429, -V2389}, '{-V9511, -V1625, -V2629}, '{-V8090, -V3090, -V5000},
        '{-V6817, V1476, -V7166}, '{-V6817, -V1476, -V7166}, '{-V8507, K0, -V5257},
        '{-V6882, V5878, -V4253}, '{-V5878, V4253, -V6882}, '{-V4253, V6882, -V5878},
        '{-V4253, -V6882, -V5878}, '{-V5878, -V4253, -V6882}, '{-V6882, -V5878, -V4253}
    };

    normal_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= NORMAL_TABLE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/nvq_dot_unit.sv -----
// dot-product and running-maximum unit, one table entry per cycle
`timescale 1ns / 1ps
`default_nettype none

module nvq_dot_unit
    import nvq_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_z,
    input  wire normal_t                           normal,
    input  wire nvq_tag_t                          tag,
    output nvq_result_t                            result
);

    localparam int PROD_W = COMPONENT_WIDTH + NORMAL_W;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  best_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic                     done_reg;
    nvq_tag_t                 tag1_reg, tag2_reg;
    logic                     take_entry;

    assign prod_x_next = PROD_W'(vec_x) * PROD_W'(normal.x);
    assign prod_y_next = PROD_W'(vec_y) * PROD_W'(normal.y);
    assign prod_z_next = PROD_W'(vec_z) * PROD_W'(normal.z);

    // exact sum, two guard bits cover three terms
    assign sum_next = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg);

    // strictly greater keeps the lowest index on ties
    assign take_entry = tag2_reg.valid && (tag2_reg.first || (sum_reg > best_reg));

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        sum_reg    <= sum_next;
        if (take_entry)
        begin
            best_reg <= sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg     <= '0;
            tag2_reg     <= '0;
            best_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            tag1_reg <= tag;
            tag2_reg <= tag1_reg;
            done_reg <= tag2_reg.valid && tag2_reg.last;
            if (take_entry)
            begin
                best_idx_reg <= tag2_reg.idx;
            end
        end
    end

    assign result.done     = done_reg;
    assign result.best_idx = best_idx_reg;

endmodule

`default_nettype wire

// ----- src/normal_vector_quantizer.sv -----
// normal vector quantizer: picks the table normal closest in direction to a vector
//
// input channel: vec_x, vec_y, vec_z (signed q1.14) with vec_valid / vec_stall.
// output channel: best_index with best_valid / best_stall.
// a beat moves when valid is high and stall is low at a rising clk edge.
// one vector is worked at a time: the unit-normal rom is read one entry per
// cycle, each entry passes a three-multiplier stage, a sum stage and a compare
// stage, so best_valid rises once the last rom read has passed the rom,
// multiply, sum, compare and output registers, and a new vector is taken only
// after the block has gone back to idle.
// vec_stall is high from the input beat until the result is loaded into the
// output register; a new vector may enter while that result still waits.
// if best_stall holds the previous result when a new one finishes, the new
// index waits in the compare unit and the input side stays stalled.
// rst_n clears all control state asynchronously; there is nothing else to
// initialize, so the block takes a vector in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module normal_vector_quantizer
    import nvq_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              vec_valid,
    output logic                                   vec_stall,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_z,
    output logic                                   best_valid,
    input  wire logic                              best_stall,
    output logic [IDX_W-1:0]                       best_index
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t                         state_reg;
    logic [IDX_W-1:0]               cnt_reg;
    logic                           best_valid_reg;
    logic [IDX_W-1:0]               best_index_reg;
    logic signed [COMPONENT_WIDTH-1:0] vx_reg, vy_reg, vz_reg;
    nvq_tag_t                       tag_reg, tag_next;
    normal_t                        rom_data;
    nvq_result_t                    result;
    logic                           accept;
    logic                           out_free;
    logic                           load_out;

    assign vec_stall = (state_reg != ST_IDLE);
    assign accept    = vec_valid && (state_reg == ST_IDLE);
    assign out_free  = !best_valid_reg || !best_stall;
    assign load_out  = out_free && ((state_reg == ST_HOLD)
                                    || ((state_reg == ST_DRAIN) && result.done));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vx_reg <= vec_x;
            vy_reg <= vec_y;
            vz_reg <= vec_z;
        end
    end

    nvq_table_rom u_rom (
        .clk     (clk),
        .rd_en   (state_reg == ST_ISSUE),
        .rd_addr (cnt_reg),
        .rd_data (rom_data)
    );

    // tag is registered alongside the rom read so it lines up with the rom data
    always_comb
    begin
        tag_next.valid = (state_reg == ST_ISSUE);
        tag_next.first = (cnt_reg == '0);
        tag_next.last  = (cnt_reg == LAST_IDX);
        tag_next.idx   = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_next;
        end
    end

    nvq_dot_unit #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_dot (
        .clk    (clk),
        .rst_n  (rst_n),
        .vec_x  (vx_reg),
        .vec_y  (vy_reg),
        .vec_z  (vz_reg),
        .normal (rom_data),
        .tag    (tag_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            best_valid_reg <= 1'b0;
            best_index_reg <= '0;
        end
        else
        begin
            if (load_out)
            begin
                best_valid_reg <= 1'b1;
                best_index_reg <= result.best_idx;
            end
            else if (best_valid_reg && !best_stall)
            begin
                best_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (vec_valid)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    cnt_reg <= IDX_W'(cnt_reg + 1'b1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (result.done)
                    begin
                        if (out_free)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    // index stays in the dot unit until the old beat leaves
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign best_valid = best_valid_reg;
    assign best_index = best_index_reg;

endmodule

`default_nettype wire

// ----- src/nvq_checker.sv -----
// port-level checker for the normal vector quantizer and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "normal_vector_quantizer_assert.svh"

module nvq_checker
    import nvq_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             vec_valid,
    input wire logic             vec_stall,
    input wire logic             best_valid,
    input wire logic             best_stall,
    input wire logic [IDX_W-1:0] best_index
);

    `NVQ_ASSERT_NOW(a_index_range, best_valid, best_index <= LAST_IDX)

    // an accepted vector always blocks the next one
    `NVQ_ASSERT_NEXT(a_busy_after_beat, vec_valid && !vec_stall, vec_stall)

    // a new result only appears after the block was busy
    `NVQ_ASSERT_NOW(a_result_from_work, $rose(best_valid), $past(vec_stall))

    `NVQ_ASSERT_NEXT(a_stalled_hold, best_valid && best_stall,
                     best_valid && $stable(best_index))

endmodule

bind normal_vector_quantizer nvq_checker u_nvq_checker (.*);

`default_nettype wire

// ----- verif/normal_vector_quantizer_tb.sv -----
// self-checking testbench of the normal vector quantizer
`timescale 1ns / 1ps

module normal_vector_quantizer_tb;

    import nvq_pkg::TABLE_ENTRIES;
    import nvq_pkg::IDX_W;

    localparam int CW            = 16;
    localparam int RANDOM_BEATS  = 1550;
    localparam int IDLE_PCT      = 23;
    localparam int CALM_FIRST    = 600;
    localparam int CALM_LAST     = 850;
    localparam int DRAIN_AT_A    = 300;
    localparam int DRAIN_AT_B    = 1100;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT   = 4000;

    // q1.14 magnitudes of the unit-normal components
    localparam int M5257 = 8614;
    localparam int M8507 = 13937;
    localparam int M4429 = 7256;
    localparam int M2389 = 3913;
    localparam int M8642 = 14159;
    localparam int M2952 = 4837;
    localparam int M9554 = 15654;
    localparam int M3090 = 5063;
    localparam int M5000 = 8192;
    localparam int M8090 = 13255;
    localparam int M1625 = 2662;
    localparam int M2629 = 4307;
    localparam int M9511 = 15582;
    localparam int MONE  = 16384;
    localparam int M1476 = 2419;
    localparam int M7166 = 11740;
    localparam int M6817 = 11169;
    localparam int M5878 = 9630;
    localparam int M4253 = 6969;
    localparam int M6882 = 11275;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vec_beat_t;

    int normal_lut [TABLE_ENTRIES][3] = '{
        '{-M5257, 0, M8507}, '{-M4429, M2389, M8642}, '{-M2952, 0, M9554},
        '{-M3090, M5000, M8090}, '{-M1625, M2629, M9511}, '{0, 0, MONE},
        '{0, M8507, M5257}, '{-M1476, M7166, M6817}, '{M1476, M7166, M6817},
        '{0, M5257, M8507}, '{M3090, M5000, M8090}, '{M5257, 0, M8507},
        '{M2952, 0, M9554}, '{M4429, M2389, M8642}, '{M1625, M2629, M9511},
        '{-M6817, M1476, M7166}, '{-M8090, M3090, M5000}, '{-M5878, M4253, M6882},
        '{-M8507, M5257, 0}, '{-M8642, M4429, M2389}, '{-M7166, M6817, M1476},
        '{-M6882, M5878, M4253}, '{-M5000, M8090, M3090}, '{-M2389, M8642, M4429},
        '{-M4253, M6882, M5878}, '{-M7166, M6817, -M1476}, '{-M5000, M8090, -M3090},
        '{-M5257, M8507, 0}, '{0, M8507, -M5257}, '{-M2389, M8642, -M4429},
        '{0, M9554, -M2952}, '{-M2629, M9511, -M1625}, '{0, MONE, 0},
        '{0, M9554, M2952}, '{-M2629, M9511, M1625}, '{M2389, M8642, M4429},
        '{M2629, M9511, M1625}, '{M5000, M8090, M3090}, '{M2389, M8642, -M4429},
        '{M2629, M9511, -M1625}, '{M5000, M8090, -M3090}, '{M8507, M5257, 0},
        '{M7166, M6817, M1476}, '{M7166, M6817, -M1476}, '{M5257, M8507, 0},
        '{M4253, M6882, M5878}, '{M8642, M4429, M2389}, '{M6882, M5878, M4253},
        '{M8090, M3090, M5000}, '{M6817, M1476, M7166}, '{M5878, M4253, M6882},
        '{M9554, M2952, 0}, '{MONE, 0, 0}, '{M9511, M1625, M2629},
        '{M8507, -M5257, 0}, '{M9554, -M2952, 0}, '{M8642, -M4429, M2389},
        '{M9511, -M1625, M2629}, '{M8090, -M3090, M5000}, '{M6817, -M1476, M7166},
        '{M8507, 0, M5257}, '{M8642, M4429, -M2389}, '{M8090, M3090, -M5000},
        '{M9511, M1625, -M2629}, '{M5257, 0, -M8507}, '{M6817, M1476, -M7166},
        '{M6817, -M1476, -M7166}, '{M8507, 0, -M5257}, '{M8090, -M3090, -M5000},
        '{M8642, -M4429, -M2389}, '{M9511, -M1625, -M2629}, '{M1476, M7166, -M6817},
        '{M3090, M5000, -M8090}, '{M4253, M6882, -M5878}, '{M4429, M2389, -M8642},
        '{M5878, M4253, -M6882}, '{M6882, M5878, -M4253}, '{-M1476, M7166, -M6817},
        '{-M3090, M5000, -M8090}, '{0, M5257, -M8507}, '{-M5257, 0, -M8507},
        '{-M4429, M2389, -M8642}, '{-M2952, 0, -M9554}, '{-M1625, M2629, -M9511},
        '{0, 0, -MONE}, '{M2952, 0, -M9554}, '{M1625, M2629, -M9511},
        '{-M4429, -M2389, -M8642}, '{-M3090, -M5000, -M8090}, '{-M1625, -M2629, -M9511},
        '{0, -M8507, -M5257}, '{-M1476, -M7166, -M6817}, '{M1476, -M7166, -M6817},
        '{0, -M5257, -M8507}, '{M3090, -M5000, -M8090}, '{M4429, -M2389, -M8642},
        '{M1625, -M2629, -M9511}, '{M2389, -M8642, -M4429}, '{M5000, -M8090, -M3090},
        '{M4253, -M6882, -M5878}, '{M7166, -M6817, -M1476}, '{M6882, -M5878, -M4253},
        '{M5878, -M4253, -M6882}, '{0, -M9554, -M2952}, '{0, -MONE, 0},
        '{M2629, -M9511, -M1625}, '{0, -M8507, M5257}, '{0, -M9554, M2952},
        '{M2389, -M8642, M4429}, '{M2629, -M9511, M1625}, '{M5000, -M8090, M3090},
        '{M7166, -M6817, M1476}, '{M5257, -M8507, 0}, '{-M2389, -M8642, -M4429},
        '{-M5000, -M8090, -M3090}, '{-M2629, -M9511, -M1625}, '{-M8507, -M5257, 0},
        '{-M7166, -M6817, -M1476}, '{-M7166, -M6817, M1476}, '{-M5257, -M8507, 0},
        '{-M5000, -M8090, M3090}, '{-M2389, -M8642, M4429}, '{-M2629, -M9511, M1625},
        '{-M8642, -M4429, M2389}, '{-M8090, -M3090, M5000}, '{-M6882, -M5878, M4253},
        '{-M6817, -M1476, M7166}, '{-M4429, -M2389, M8642}, '{-M5878, -M4253, M6882},
        '{-M3090, -M5000, M8090}, '{-M1476, -M7166, M6817}, '{-M4253, -M6882, M5878},
        '{-M1625, -M2629, M9511}, '{M4429, -M2389, M8642}, '{M1625, -M2629, M9511},
        '{M3090, -M5000, M8090}, '{M1476, -M7166, M6817}, '{0, -M5257, M8507},
        '{M4253, -M6882, M5878}, '{M5878, -M4253, M6882}, '{M6882, -M5878, M4253},
        '{-M9554, M2952, 0}, '{-M9511, M1625, M2629}, '{-MONE, 0, 0},
        '{-M8507, 0, M5257}, '{-M9554, -M2952, 0}, '{-M9511, -M1625, M2629},
        '{-M8642, M4429, -M2389}, '{-M9511, M1625, -M2629}, '{-M8090, M3090, -M5000},
        '{-M8642, -M4429, -M2389}, '{-M9511, -M1625, -M2629}, '{-M8090, -M3090, -M5000},
        '{-M6817, M1476, -M7166}, '{-M6817, -M1476, -M7166}, '{-M8507, 0, -M5257},
        '{-M6882, M5878, -M4253}, '{-M5878, M4253, -M6882}, '{-M4253, M6882, -M5878},
        '{-M4253, -M6882, -M5878}, '{-M5878, -M4253, -M6882}, '{-M6882, -M5878, -M4253}
    };

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 vec_valid  = 1'b0;
    logic signed [CW-1:0] vec_x      = '0;
    logic signed [CW-1:0] vec_y      = '0;
    logic signed [CW-1:0] vec_z      = '0;
    logic                 best_stall = 1'b0;
    logic                 vec_stall;
    logic                 best_valid;
    logic [IDX_W-1:0]     best_index;

    vec_beat_t        vector_q [$];
    logic [IDX_W-1:0] best_index_q [$];
    logic             vec_taken   = 1'b0;
    int               issued      = 0;
    bit               drain_req   = 1'b0;
    int               error_count = 0;
    int               quiet_cycles = 0;

    normal_vector_quantizer #(
        .COMPONENT_WIDTH(CW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_stall (vec_stall),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .best_valid(best_valid),
        .best_stall(best_stall),
        .best_index(best_index)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // exact dot product against every normal, strictly greater wins
    function automatic logic [IDX_W-1:0] nearest_normal(input logic signed [CW-1:0] x,
                                                        input logic signed [CW-1:0] y,
                                                        input logic signed [CW-1:0] z);
        longint dot;
        longint best_dot;
        int     best_at;
        best_dot = 0;
        best_at  = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            dot = longint'(x) * normal_lut[i][0] + longint'(y) * normal_lut[i][1]
                + longint'(z) * normal_lut[i][2];
            if (i == 0 || dot > best_dot)
            begin
                best_dot = dot;
                best_at  = i;
            end
        end
        return IDX_W'(best_at);
    endfunction

    function automatic logic signed [CW-1:0] clamp_component(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] corner_value();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    function automatic vec_beat_t random_vector();
        vec_beat_t b;
        int        kind;
        int        i;
        int        j;
        int        scale;
        kind = $urandom_range(0, 99);
        i    = $urandom_range(0, TABLE_ENTRIES - 1);
        j    = $urandom_range(0, TABLE_ENTRIES - 1);
        if (kind < 35)
        begin
            b.x = CW'($urandom());
            b.y = CW'($urandom());
            b.z = CW'($urandom());
        end
        else if (kind < 55)
        begin
            // tiny vectors tie often through table rounding
            b.x = CW'(int'($urandom_range(0, 6)) - 3);
            b.y = CW'(int'($urandom_range(0, 6)) - 3);
            b.z = CW'(int'($urandom_range(0, 6)) - 3);
        end
        else if (kind < 80)
        begin
            scale = $urandom_range(1, 3);
            b.x = clamp_component(normal_lut[i][0] * scale / 2
                                  + int'($urandom_range(0, 64)) - 32);
            b.y = clamp_component(normal_lut[i][1] * scale / 2
                                  + int'($urandom_range(0, 64)) - 32);
            b.z = clamp_component(normal_lut[i][2] * scale / 2
                                  + int'($urandom_range(0, 64)) - 32);
        end
        else if (kind < 92)
        begin
            // halfway between two normals sits near a decision boundary
            b.x = clamp_component(normal_lut[i][0] + normal_lut[j][0]);
            b.y = clamp_component(normal_lut[i][1] + normal_lut[j][1]);
            b.z = clamp_component(normal_lut[i][2] + normal_lut[j][2]);
        end
        else
        begin
            b.x = corner_value();
            b.y = corner_value();
            b.z = corner_value();
        end
        return b;
    endfunction

    task automatic queue_vector(input int x, input int y, input int z);
        vector_q.push_back('{x: CW'(x), y: CW'(y), z: CW'(z)});
    endtask

    task automatic report_mismatch(input string what);
        $display("normal_vector_quantizer_tb: mismatch: %s", what);
        error_count++;
    endtask

    // sender and receiver, both moving at the falling edge
    always @(negedge clk)
    begin
        bit calm;
        vec_beat_t b;
        if (!rst_n)
        begin
            vec_valid  <= 1'b0;
            best_stall <= 1'b0;
        end
        else
        begin
            calm = (issued >= CALM_FIRST && issued < CALM_LAST);
            if (drain_req && best_index_q.size() == 0)
                drain_req = 1'b0;
            if (!vec_valid || vec_taken)
            begin
                if (vector_q.size() != 0 && !drain_req
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    b = vector_q.pop_front();
                    vec_x     <= b.x;
                    vec_y     <= b.y;
                    vec_z     <= b.z;
                    vec_valid <= 1'b1;
                    issued++;
                    // hold off after this beat until every index is back
                    if (issued == DRAIN_AT_A || issued == DRAIN_AT_B)
                        drain_req = 1'b1;
                end
                else
                    vec_valid <= 1'b0;
            end
            best_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // monitor: predict on each input beat, check each output beat
    always @(posedge clk)
    begin
        logic [IDX_W-1:0] want;
        if (rst_n)
        begin
            vec_taken <= vec_valid && !vec_stall;
            if (vec_valid && !vec_stall)
                best_index_q.push_back(nearest_normal(vec_x, vec_y, vec_z));
            if (best_valid && !best_stall)
            begin
                if (best_index_q.size() == 0)
                    report_mismatch($sformatf("unexpected best_index %0d", best_index));
                else
                begin
                    want = best_index_q.pop_front();
                    if (best_index !== want)
                        report_mismatch($sformatf("best_index got %0d want %0d",
                                                  best_index, want));
                end
            end
        end
    end

    // watchdog on cycles with work outstanding and no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vec_valid && !vec_stall) || (best_valid && !best_stall)
                || (vector_q.size() == 0 && best_index_q.size() == 0 && !vec_valid))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("normal_vector_quantizer_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        queue_vector(0, 0, 0);
        queue_vector(32767, 0, 0);
        queue_vector(-32768, 0, 0);
        queue_vector(0, 32767, 0);
        queue_vector(0, -32768, 0);
        queue_vector(0, 0, 32767);
        queue_vector(0, 0, -32768);
        queue_vector(32767, 32767, 32767);
        queue_vector(-32768, -32768, -32768);
        queue_vector(32767, -32768, 32767);
        queue_vector(-32768, 32767, -32768);
        queue_vector(-32768, -32768, 32767);
        queue_vector(32767, 32767, -32768);
        queue_vector(1, 0, 0);
        queue_vector(-1, -1, -1);
        queue_vector(1, 1, 0);
        queue_vector(0, 1, -1);
        queue_vector(16384, 16384, 0);
        queue_vector(21845, -21846, 21845);
        queue_vector(-M5257, 0, M8507);
        queue_vector(-M6882 * 2, -M5878 * 2, -M4253 * 2);
        queue_vector(M8507 + MONE, 0, M5257);
        for (int n = 0; n < RANDOM_BEATS; n++)
            vector_q.push_back(random_vector());

        while (vector_q.size() != 0 || vec_valid || best_index_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("normal_vector_quantizer_tb: done, clean");
        else
            $display("normal_vector_quantizer_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/nvq_pkg.sv
src/nvq_table_rom.sv
src/nvq_dot_unit.sv
src/normal_vector_quantizer.sv
src/nvq_checker.sv
verif/normal_vector_quantizer_tb.sv
